### hw/rtl/kbacc_pkg.sv
`default_nettype none

package kbacc_pkg;

   // Keyboard layout codes held in the layout_select register.
   localparam logic [1:0] KEYMAP_ENGLISH = 2'd0;
   localparam logic [1:0] KEYMAP_FRENCH  = 2'd1;
   localparam logic [1:0] KEYMAP_GERMAN  = 2'd2;
   localparam logic [1:0] KEYMAP_INVALID = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_LAYOUT_SELECT = 1'b0;
   localparam logic CSR_CYCLE_WINDOW  = 1'b1;

   localparam logic [15:0] CYCLE_WINDOW_RESET = 16'd500;
   localparam logic [7:0]  CASE_BIT           = 8'h20;
   localparam logic [7:0]  SHARP_S            = 8'hDF;

   typedef struct packed {
      logic [7:0]  raw_key;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       replace_previous;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  layout_select;
      logic [15:0] cycle_window_ms;
   } cfg_type;

   // Swap the letters that sit on different keys in the French and German layouts.
   function automatic logic [7:0] kbacc_remap(input logic [7:0] c, input logic [1:0] lay);
      logic [7:0] r;
      r = c;
      if (lay == KEYMAP_FRENCH) begin
         case (c)
            "q":     r = "a";
            "a":     r = "q";
            "w":     r = "z";
            "z":     r = "w";
            default: r = c;
         endcase
      end else if (lay == KEYMAP_GERMAN) begin
         case (c)
            "y":     r = "z";
            "z":     r = "y";
            default: r = c;
         endcase
      end
      return r;
   endfunction

   // Number of variants for a lowercase base letter; zero means no accent row.
   function automatic logic [2:0] kbacc_row_len(input logic [1:0] lay, input logic [7:0] base);
      logic [2:0] n;
      n = 3'd0;
      if (lay == KEYMAP_FRENCH) begin
         case (base)
            "e":     n = 3'd5;
            "a":     n = 3'd3;
            "u":     n = 3'd4;
            "i":     n = 3'd3;
            "o":     n = 3'd2;
            "c":     n = 3'd2;
            default: n = 3'd0;
         endcase
      end else if (lay == KEYMAP_GERMAN) begin
         case (base)
            "a", "o", "u", "s": n = 3'd2;
            default:            n = 3'd0;
         endcase
      end
      return n;
   endfunction

   // Latin-1 character for a variant. Uppercase accented letters sit 0x20 below
   // the lowercase ones, except the sharp s, which has no capital form here.
   function automatic logic [7:0] kbacc_variant(input logic [1:0] lay, input logic [7:0] base,
                                                input logic upper, input logic [2:0] idx);
      logic [7:0] lo;
      lo = 8'h00;
      if (idx == 3'd0) begin
         lo = base;
      end else if (lay == KEYMAP_FRENCH) begin
         case ({base, idx})
            {8'("e"), 3'd1}: lo = 8'hE9;
            {8'("e"), 3'd2}: lo = 8'hE8;
            {8'("e"), 3'd3}: lo = 8'hEA;
            {8'("e"), 3'd4}: lo = 8'hEB;
            {8'("a"), 3'd1}: lo = 8'hE0;
            {8'("a"), 3'd2}: lo = 8'hE2;
            {8'("u"), 3'd1}: lo = 8'hF9;
            {8'("u"), 3'd2}: lo = 8'hFB;
            {8'("u"), 3'd3}: lo = 8'hFC;
            {8'("i"), 3'd1}: lo = 8'hEE;
            {8'("i"), 3'd2}: lo = 8'hEF;
            {8'("o"), 3'd1}: lo = 8'hF4;
            {8'("c"), 3'd1}: lo = 8'hE7;
            default:         lo = 8'h00;
         endcase
      end else begin
         case (base)
            "a":     lo = 8'hE4;
            "o":     lo = 8'hF6;
            "u":     lo = 8'hFC;
            "s":     lo = SHARP_S;
            default: lo = 8'h00;
         endcase
      end
      if (upper && lo != SHARP_S) begin
         lo = lo - CASE_BIT;
      end
      return lo;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/kbacc_csr.sv
`default_nettype none

module kbacc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_data,
   output kbacc_pkg::cfg_type     cfg
);
   import kbacc_pkg::*;

   logic [1:0]  layout_ff, layout_in;
   logic [15:0] window_ff, window_in;

   always_comb begin
      layout_in = layout_ff;
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LAYOUT_SELECT: layout_in = csr_data[1:0];
            CSR_CYCLE_WINDOW:  window_in = csr_data;
            default:           layout_in = layout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= KEYMAP_ENGLISH;
         window_ff <= CYCLE_WINDOW_RESET;
      end else begin
         layout_ff <= layout_in;
         window_ff <= window_in;
      end
   end

   assign cfg.layout_select   = layout_ff;
   assign cfg.cycle_window_ms = window_ff;

endmodule

`default_nettype wire

### hw/rtl/kbacc_cycle.sv
`default_nettype none

module kbacc_cycle (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire kbacc_pkg::req_type item,
   input  wire kbacc_pkg::cfg_type cfg,
   output kbacc_pkg::rsp_type      result
);
   import kbacc_pkg::*;

   // Cycle state. A zero base never matches a letter, so a cleared cycle
   // cannot be continued whatever the other fields hold.
   logic [7:0]  base_ff, base_in;
   logic        upper_ff, upper_in;
   logic [2:0]  index_ff, index_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [1:0]  layout_ff, layout_in;

   logic [7:0]  raw;
   logic [1:0]  lay;
   logic        is_ext, is_pass, is_lower, is_upper, is_letter;
   logic [7:0]  base;
   logic [7:0]  plain;
   logic [2:0]  row_len;
   logic        has_row;
   logic [31:0] delta;
   logic        cont;
   logic [2:0]  index_inc, index_next;
   logic        clear;

   always_comb begin
      raw       = item.raw_key;
      lay       = cfg.layout_select;
      is_ext    = raw[7];
      is_pass   = (lay == KEYMAP_ENGLISH) || (lay == KEYMAP_INVALID);
      is_lower  = (raw >= "a") && (raw <= "z");
      is_upper  = (raw >= "A") && (raw <= "Z");
      is_letter = is_lower || is_upper;
      base      = kbacc_remap(raw | CASE_BIT, lay);
      plain     = is_upper ? (base & ~CASE_BIT) : base;
      row_len   = kbacc_row_len(lay, base);
      has_row   = (row_len != 3'd0);
      delta     = item.now_ms - stamp_ff;
      cont      = has_row && (base_ff == base) && (layout_ff == lay) &&
                  (upper_ff == is_upper) && (stamp_ff != 32'd0) &&
                  (delta < {16'd0, cfg.cycle_window_ms});
      index_inc  = index_ff + 3'd1;
      index_next = (index_inc == row_len) ? 3'd0 : index_inc;
      clear      = is_ext || is_pass || !is_letter || !has_row;

      result.replace_previous = 1'b0;
      if (is_ext) begin
         result.char_out = 8'h00;
      end else if (is_pass || !is_letter) begin
         result.char_out = raw;
      end else if (cont) begin
         result.char_out         = kbacc_variant(lay, base, is_upper, index_next);
         result.replace_previous = 1'b1;
      end else begin
         result.char_out = plain;
      end

      base_in   = base_ff;
      upper_in  = upper_ff;
      index_in  = index_ff;
      stamp_in  = stamp_ff;
      layout_in = layout_ff;
      if (advance) begin
         if (clear) begin
            base_in   = 8'h00;
            upper_in  = 1'b0;
            index_in  = 3'd0;
            stamp_in  = 32'd0;
            layout_in = KEYMAP_INVALID;
         end else if (cont) begin
            index_in = index_next;
            stamp_in = item.now_ms;
         end else begin
            base_in   = base;
            upper_in  = is_upper;
            index_in  = 3'd0;
            stamp_in  = item.now_ms;
            layout_in = lay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 8'h00;
         upper_ff  <= 1'b0;
         index_ff  <= 3'd0;
         stamp_ff  <= 32'd0;
         layout_ff <= KEYMAP_INVALID;
      end else begin
         base_ff   <= base_in;
         upper_ff  <= upper_in;
         index_ff  <= index_in;
         stamp_ff  <= stamp_in;
         layout_ff <= layout_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/keyboard_layout_accent_cycler_top.sv
`default_nettype none
// A request waits in the input register, then moves on to the result register.
// Throughput: one request per cycle while the consumer keeps rsp_ready high; the input
// register refills in the same cycle that its request moves to the result register, and
// the result register frees itself in the cycle the consumer takes it.
// Reset: synchronous, active high; clears both pipeline registers, the accent
// cycle state, and sets the layout to English and the window to 500 ms.

module keyboard_layout_accent_cycler_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire kbacc_pkg::req_type  req_payload,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output kbacc_pkg::rsp_type       rsp_payload,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic                csr_index,
   input  wire logic [15:0]         csr_data
);
   import kbacc_pkg::*;

   // Input register: holds one request until the translation stage can pass
   // it on. The cycle state is read by the translation logic and updated at
   // the same edge that moves the request into the result register, so the
   // next request always sees the state its predecessor left behind.
   logic    in_full_ff, in_full_in;
   req_type in_item_ff, in_item_in;

   // Result register: parts the consumer from the translation logic.
   logic    out_full_ff, out_full_in;
   rsp_type out_item_ff, out_item_in;

   logic    advance;
   rsp_type result;
   cfg_type cfg;

   // Configuration writes are always taken; the registers feed the
   // translation logic directly.
   assign csr_ready = 1'b1;

   kbacc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The request moves on when the result register is empty or is being
   // emptied in this cycle.
   assign advance   = in_full_ff && (!out_full_ff || rsp_ready);
   assign req_ready = !in_full_ff || advance;

   kbacc_cycle u_cycle (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_full_in  = in_full_ff;
      in_item_in  = in_item_ff;
      out_full_in = out_full_ff;
      out_item_in = out_item_ff;

      if (rsp_ready) begin
         out_full_in = 1'b0;
      end
      if (advance) begin
         out_full_in = 1'b1;
         out_item_in = result;
         in_full_in  = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_full_in = 1'b1;
         in_item_in = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff  <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_full_ff;
   assign rsp_payload = out_item_ff;

`ifndef SYNTHESIS
   // A request leaving the input register always lands in the result register.
   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register empty after a request advanced");

   // An extended key byte always comes out as a plain zero.
   a_extended_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.raw_key[7]) |=>
      (rsp_payload.char_out == 8'h00 && !rsp_payload.replace_previous))
      else $error("extended key byte did not give zero");

   // Accent cycling only exists in the French and German layouts.
   a_replace_needs_layout: assert property (@(posedge clock) disable iff (reset)
      (advance && result.replace_previous) |->
      (cfg.layout_select == KEYMAP_FRENCH || cfg.layout_select == KEYMAP_GERMAN))
      else $error("replace flag outside an accent layout");

   // The input register never accepts a request while holding one that cannot move.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_full_ff && !advance) |-> !req_ready)
      else $error("input register overwritten");
`endif

endmodule

`default_nettype wire
